[design/wbps_pkg.sv]
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants for the wildcard byte pattern search block.
// ----------------------------------------------------------------------------
package wbps_pkg;

	// window depth and byte counter width
	localparam int MAX_PATTERN = 16;
	localparam int COUNT_BITS  = 32;
	localparam int POS_BITS    = $clog2(MAX_PATTERN);
	localparam int LEN_BITS    = $clog2(MAX_PATTERN + 1);

	// configuration port
	localparam int CFG_DATA_BITS = 64;
	localparam int CFG_IDX_BITS  = 3;

	localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_LOW  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_HIGH = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_WILDCARD     = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_LENGTH       = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_BASE         = 3'd4;

	// register reset values
	localparam logic [4:0]  LENGTH_RESET = 5'd1;
	localparam logic [31:0] BASE_RESET   = 32'h0040_1000;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic        found;
		logic [31:0] match_address;
	} out_item_t;

	// per-cell compare setup
	typedef struct packed {
		logic       care;
		logic [7:0] sig_byte;
	} cell_cmp_t;

endpackage

[design/wbps_cell.sv]
// ----------------------------------------------------------------------------
// wbps_cell
// One window cell: holds one byte, passes it to its neighbor on each shift
// and checks the incoming byte against its signature position.
// ----------------------------------------------------------------------------
module wbps_cell (
	input  logic                clk,
	input  logic                shift,
	input  logic [7:0]          byte_in,
	input  wbps_pkg::cell_cmp_t cmp,
	output logic [7:0]          byte_out,
	output logic                hit
);

	logic [7:0] byte_q;

	// advance the window by one byte
	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= byte_in;
		end
	end

	assign byte_out = byte_q;

	// compare the byte this cell takes on the current shift
	assign hit = !cmp.care || (byte_in == cmp.sig_byte);

endmodule

[design/wildcard_byte_pattern_search.sv]
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_search
// Scans a byte stream for the first match of a signature with wildcards.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one byte of the region per transaction; last_byte marks its end.
//   out_*  : at most one result per region: found with base plus start
//            offset, or not found (address zero) when the region ends.
//   cfg_*  : write enable, register index and data; write only while idle.
// Throughput: one byte per cycle while in_ready is high. Window cells
//   shift in parallel; each compares its byte in the same cycle as the shift.
// Result path: the byte that causes a result is registered in the match
//   stage, then the base address is added into the output register.
// Reset: clears configuration to defaults, the byte count and the match
//   flag; the pipeline starts empty.
// Stall: while out_ready is low, one result waits in the output register and
//   one more in the match stage; in_ready drops only when both are full.
// After a match, bytes up to the end of the region are taken and dropped.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_search (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  wbps_pkg::in_item_t                     in_data,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output wbps_pkg::out_item_t                    out_data,
	input  logic                                   cfg_we,
	input  logic [wbps_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [wbps_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

	localparam int N  = wbps_pkg::MAX_PATTERN;
	localparam int CB = wbps_pkg::COUNT_BITS;
	localparam int LB = wbps_pkg::LEN_BITS;
	localparam int PB = wbps_pkg::POS_BITS;

	// configuration registers
	logic [63:0]   pat_low_q;
	logic [63:0]   pat_high_q;
	logic [N-1:0]  wild_q;
	logic [4:0]    length_q;
	logic [31:0]   base_q;

	// region state
	logic [CB-1:0] count_q;
	logic          reported_q;

	// match stage and output register
	logic          valid_s1;
	logic          found_s1;
	logic [CB-1:0] offset_s1;
	logic          out_valid_q;
	wbps_pkg::out_item_t out_q;

	logic          accept;
	logic          s1_move;
	logic          out_load;
	logic          shift;
	logic [LB-1:0] len_eff;
	logic [CB-1:0] count_new;
	logic          hit;
	logic [N*8-1:0] sig_all;
	logic [7:0]    cell_in  [N];
	logic [7:0]    cell_out [N];
	logic [N-1:0]  cell_hit;
	wbps_pkg::cell_cmp_t cell_cmp [N];

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			wild_q     <= '0;
			length_q   <= wbps_pkg::LENGTH_RESET;
			base_q     <= wbps_pkg::BASE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				wbps_pkg::REG_PATTERN_LOW:  pat_low_q  <= cfg_data;
				wbps_pkg::REG_PATTERN_HIGH: pat_high_q <= cfg_data;
				wbps_pkg::REG_WILDCARD:     wild_q     <= cfg_data[N-1:0];
				wbps_pkg::REG_LENGTH:       length_q   <= cfg_data[4:0];
				wbps_pkg::REG_BASE:         base_q     <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// clamp length to 1..MAX_PATTERN
	always_comb begin
		if (length_q == 5'd0) begin
			len_eff = LB'(1);
		end else if (32'(length_q) > N) begin
			len_eff = LB'(N);
		end else begin
			len_eff = LB'(length_q);
		end
	end

	assign sig_all = {pat_high_q, pat_low_q};

	// handshake flow
	assign out_load = !out_valid_q || out_ready;
	assign s1_move  = valid_s1 && out_load;
	assign in_ready = !valid_s1 || s1_move;
	assign accept   = in_valid && in_ready;
	assign shift    = accept && !reported_q;

	// cell k compares the byte k steps before the current one to position len-1-k
	genvar k;
	generate
		for (k = 0; k < N; k++) begin : g_cell
			logic [LB-1:0] pos;

			if (k == 0) begin : g_head
				assign cell_in[k] = in_data.data_byte;
			end else begin : g_link
				assign cell_in[k] = cell_out[k-1];
			end

			assign pos = len_eff - LB'(1) - LB'(k);
			assign cell_cmp[k].care = (LB'(k) < len_eff) && !wild_q[pos[PB-1:0]];
			assign cell_cmp[k].sig_byte = sig_all[pos[PB-1:0]*8 +: 8];

			wbps_cell u_cell (
				.clk      (clk),
				.shift    (shift),
				.byte_in  (cell_in[k]),
				.cmp      (cell_cmp[k]),
				.byte_out (cell_out[k]),
				.hit      (cell_hit[k])
			);
		end
	endgenerate

	// saturating count including this byte
	assign count_new = (&count_q) ? count_q : count_q + CB'(1);
	assign hit       = (count_new >= CB'(len_eff)) && (&cell_hit);

	// track region state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			reported_q <= 1'b0;
		end else if (accept) begin
			if (in_data.last_byte) begin
				count_q    <= '0;
				reported_q <= 1'b0;
			end else if (!reported_q) begin
				count_q <= count_new;
				if (hit) begin
					reported_q <= 1'b1;
				end
			end
		end
	end

	// match stage: hold a pending result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= !reported_q && (hit || in_data.last_byte);
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			found_s1  <= hit;
			offset_s1 <= count_new - CB'(len_eff);
		end
	end

	// output register: add the base address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && valid_s1) begin
			out_q.found         <= found_s1;
			out_q.match_address <= found_s1 ? base_q + 32'(offset_s1) : 32'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef NO_ASSERTIONS
	// a not-found result never carries an address
	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.found |-> out_q.match_address == 32'd0)
		else $error("not-found result with nonzero address");

	// end of region resets the region state
	a_region_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_data.last_byte |=> count_q == '0 && !reported_q)
		else $error("region state not cleared after last byte");

	// a hit inside a region sets the flag that suppresses further results and queues a result
	a_hit_latch: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !reported_q && hit && !in_data.last_byte |=> reported_q && valid_s1)
		else $error("match not recorded");
`endif

endmodule
